### hdl/mwpo_pkg.sv
// shared types, constants and the quarter-wave sine table builder
// for the multi-waveform phase oscillator; no dependencies
package mwpo_pkg;

    // phase accumulator and sine table geometry
    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QTAB_N          = 1 << SINE_TABLE_BITS;
    localparam int QADDR_BITS      = SINE_TABLE_BITS + 1;

    // field widths
    localparam int SAMPLE_BITS    = 16;
    localparam int FREQ_BITS      = 32;
    localparam int WIDTH_BITS     = 16;
    localparam int SCALE_BITS     = 32;
    localparam int WAVE_BITS      = 3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // increment product: signed freq times zero-extended scale
    localparam int PROD_BITS = FREQ_BITS + SCALE_BITS + 1;
    // compare domain: phase scaled to a 48-bit turn
    localparam int CMP_BITS  = 48;

    // pulse threshold arithmetic
    localparam int MAG_BITS          = WIDTH_BITS + 1;
    localparam int X7_BITS           = MAG_BITS + 1;
    localparam int RECIP_BITS        = 19;
    localparam int RECIP_PROD_BITS   = X7_BITS + RECIP_BITS;
    localparam int RECIP_SHIFT       = 23;
    localparam int TH_BASE_BITS      = MAG_BITS + 17;
    localparam int TH_BITS           = 32;
    localparam int TH_SHIFT          = 16;
    // a*99*2^17/100 = a*129761 + a*7/25
    localparam logic [16:0]             PULSE_MUL_INT  = 17'd129761;
    localparam logic [RECIP_BITS-1:0]   PULSE_RECIP    = 19'd335545;
    localparam logic [MAG_BITS-1:0]     PULSE_SMALL_MAX = 17'd330;
    localparam logic [TH_BITS-1:0]      PULSE_SMALL_ADD = 32'd42949672;

    // intermediate width for non-sine waveform math
    localparam int RAW_BITS = 19;

    // queue geometry
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
    localparam int Q_COUNT_BITS = $clog2(Q_DEPTH + 1);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_SCALE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM   = 2'd1;

    // reset values
    localparam logic [SCALE_BITS-1:0] STEP_SCALE_RESET = 32'd22906492;
    localparam logic [WAVE_BITS-1:0]  WAVEFORM_RESET   = 3'd0;

    // waveform codes
    localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd1;
    localparam logic [WAVE_BITS-1:0] WAVE_PULSE    = 3'd2;
    localparam logic [WAVE_BITS-1:0] WAVE_SAW_DOWN = 3'd3;
    localparam logic [WAVE_BITS-1:0] WAVE_SAW_UP   = 3'd4;
    localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd5;
    // unused codes, silent output
    localparam logic [WAVE_BITS-1:0] WAVE_SPARE_LO = 3'd6;
    localparam logic [WAVE_BITS-1:0] WAVE_SPARE_HI = 3'd7;

    // q1.15 limits
    localparam logic signed [SAMPLE_BITS-1:0] Q15_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] Q15_MIN = 16'sh8000;

    // sine table generation constants
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int TAYLOR_TERMS = 6;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // one item moved from the front to the back
    typedef struct packed {
        logic [PHASE_BITS-1:0] inc;
        logic [TH_BITS-1:0]    pulse_th;
    } qent_t;

    typedef logic [SAMPLE_BITS-1:0] qtab_t [QTAB_N+1];

    // quarter-wave table, taylor series to x^13 in q30, worked out at elaboration
    function automatic qtab_t build_qtab();
        qtab_t       tab;
        logic [63:0] x;
        logic [63:0] t;
        logic signed [63:0] s;
        logic [63:0] v;
        for (int i = 0; i <= QTAB_N; i++)
        begin
            x = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            t = x;
            s = $signed(x);
            for (int n = 1; n <= TAYLOR_TERMS; n++)
            begin
                t = (((t * x) >> 30) * x) >> 30;
                t = t / TAYLOR_DIV[n-1];
                if ((n % 2) == 1)
                    s = s - $signed(t);
                else
                    s = s + $signed(t);
            end
            if (s < 0)
                v = 64'd0;
            else
                v = (($unsigned(s) * 64'd32768) + (64'd1 << 29)) >> 30;
            if (v > 64'd32768)
                v = 64'd32768;
            tab[i] = v[SAMPLE_BITS-1:0];
        end
        return tab;
    endfunction

endpackage

### hdl/mwpo_front.sv
// front end: takes input beats, works out the phase increment and pulse threshold
// depends on mwpo_pkg
module mwpo_front
    import mwpo_pkg::*;
(
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [FREQ_BITS-1:0]  freq,
    input  logic signed [WIDTH_BITS-1:0] pwm_width,
    input  logic [SCALE_BITS-1:0]        step_scale,
    output logic                         push,
    input  logic                         push_ready,
    output qent_t                        push_ent
);

    logic signed [PROD_BITS-1:0]     prod;
    logic [MAG_BITS-1:0]             mag;
    logic [X7_BITS-1:0]              x7;
    logic [RECIP_PROD_BITS-1:0]      recip_prod;
    logic [TH_BASE_BITS-1:0]         th_base;
    logic [TH_BITS-1:0]              th_sum;

    // handshake: stall only while the queue is full
    assign in_stall = !push_ready;
    assign push     = in_valid && push_ready;

    // phase increment, two's complement product taken modulo one turn
    assign prod = $signed(freq) * $signed({1'b0, step_scale});

    // queue entry: increment and pulse threshold from the width magnitude
    always_comb
    begin
        push_ent.inc = prod[CMP_BITS-1 -: PHASE_BITS];
        if (pwm_width[WIDTH_BITS-1])
            mag = MAG_BITS'(17'h10000) - {1'b0, pwm_width};
        else
            mag = {1'b0, pwm_width};
        x7         = {mag, 1'b0} + X7_BITS'(mag) + X7_BITS'({mag, 1'b0}) * X7_BITS'(2);
        recip_prod = RECIP_PROD_BITS'(x7) * RECIP_PROD_BITS'(PULSE_RECIP);
        th_base    = TH_BASE_BITS'(mag) * TH_BASE_BITS'(PULSE_MUL_INT);
        th_sum     = TH_BITS'(th_base + TH_BASE_BITS'(recip_prod >> RECIP_SHIFT));
        if (mag <= PULSE_SMALL_MAX)
            push_ent.pulse_th = th_sum + PULSE_SMALL_ADD;
        else
            push_ent.pulse_th = th_sum;
    end

endmodule

### hdl/mwpo_queue.sv
// short fifo that parts the front end from the back end
// depends on mwpo_pkg
module mwpo_queue
    import mwpo_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  push_ready,
    input  qent_t push_ent,
    output logic  pop_valid,
    input  logic  pop,
    output qent_t pop_ent
);

    qent_t                   mem_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_COUNT_BITS-1:0] count_reg, count_next;

    assign push_ready = (count_reg != Q_COUNT_BITS'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_ent    = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_ent;
    end

endmodule

### hdl/mwpo_back.sv
// back end: phase accumulator, sine rom, waveform shaping and output register
// depends on mwpo_pkg
module mwpo_back
    import mwpo_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [WAVE_BITS-1:0]          waveform,
    input  logic                          pop_valid,
    output logic                          pop,
    input  qent_t                         pop_ent,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    localparam qtab_t SINE_QTAB = build_qtab();

    logic [PHASE_BITS-1:0]         phase_reg;
    logic                          b1_valid_reg, b1_valid_next;
    logic                          b1_sine_reg;
    logic                          b1_neg_reg;
    logic [SAMPLE_BITS-1:0]        b1_val_reg;
    logic [SAMPLE_BITS-1:0]        rom_reg;
    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        sample_reg, sample_next;

    logic                          out_load;
    logic                          b1_load;
    logic [1:0]                    quad;
    logic [SINE_TABLE_BITS-1:0]    jidx;
    logic [QADDR_BITS-1:0]         rom_addr;
    logic                          le_half;
    logic                          pulse_hit;
    logic [CMP_BITS-1:0]           ph_cmp;
    logic [CMP_BITS-1:0]           th_cmp;
    logic signed [RAW_BITS-1:0]    p16;
    logic signed [RAW_BITS-1:0]    raw;
    logic [SAMPLE_BITS-1:0]        val_next;
    logic signed [SAMPLE_BITS:0]   sine_mag;

    function automatic logic [SAMPLE_BITS-1:0] sat_q15(input logic signed [RAW_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] r;
        if (v > RAW_BITS'(Q15_MAX))
            r = Q15_MAX;
        else if (v < RAW_BITS'(Q15_MIN))
            r = Q15_MIN;
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

    // pipeline handshake
    assign out_load = !out_valid_reg || !out_stall;
    assign b1_load  = !b1_valid_reg || out_load;
    assign pop      = pop_valid && b1_load;

    // phase decode for the current beat
    always_comb
    begin
        quad      = phase_reg[PHASE_BITS-1 -: 2];
        jidx      = phase_reg[PHASE_BITS-3 -: SINE_TABLE_BITS];
        rom_addr  = quad[0] ? (QADDR_BITS'(QTAB_N) - QADDR_BITS'(jidx)) : QADDR_BITS'(jidx);
        le_half   = !phase_reg[PHASE_BITS-1] || (phase_reg[PHASE_BITS-2:0] == '0);
        ph_cmp    = CMP_BITS'(phase_reg) << (CMP_BITS - PHASE_BITS);
        th_cmp    = CMP_BITS'(pop_ent.pulse_th) << TH_SHIFT;
        pulse_hit = (ph_cmp <= th_cmp);
        p16       = $signed(RAW_BITS'(phase_reg[PHASE_BITS-1 -: SAMPLE_BITS]));
    end

    // non-sine waveforms
    always_comb
    begin
        case (waveform)
            WAVE_SQUARE:   raw = le_half ? RAW_BITS'(Q15_MAX) : RAW_BITS'(Q15_MIN);
            WAVE_PULSE:    raw = pulse_hit ? RAW_BITS'(Q15_MAX) : RAW_BITS'(Q15_MIN);
            WAVE_SAW_DOWN: raw = 19'sd32768 - p16;
            WAVE_SAW_UP:   raw = p16 - 19'sd32768;
            WAVE_TRIANGLE: raw = le_half ? ((p16 <<< 1) - 19'sd32768)
                                         : (19'sd98304 - (p16 <<< 1));
            default:       raw = '0;
        endcase
        val_next = sat_q15(raw);
    end

    // first back stage: phase advance and rom read
    assign b1_valid_next = b1_load ? pop : b1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            b1_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= b1_valid_next;
            if (pop)
                phase_reg <= phase_reg + pop_ent.inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rom_reg     <= SINE_QTAB[rom_addr];
            b1_sine_reg <= (waveform == WAVE_SINE);
            b1_neg_reg  <= quad[1];
            b1_val_reg  <= val_next;
        end
    end

    // sine sign and saturation, then output register
    always_comb
    begin
        sine_mag = $signed({1'b0, rom_reg});
        if (!b1_sine_reg)
            sample_next = b1_val_reg;
        else if (b1_neg_reg)
            sample_next = SAMPLE_BITS'(-sine_mag);
        else if (sine_mag > (SAMPLE_BITS+1)'(Q15_MAX))
            sample_next = Q15_MAX;
        else
            sample_next = rom_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= b1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && b1_valid_reg)
            sample_reg <= sample_next;
    end

    assign out_valid = out_valid_reg;
    assign sample    = $signed(sample_reg);

endmodule

### hdl/multi_waveform_phase_oscillator_core.sv
// multi-waveform phase oscillator, top level: configuration registers and
// front, queue and back hookup; a beat passes the queue, first back stage and output
// register, one beat per cycle unless stalled, bounded by the phase add in the back
// end; asynchronous active-low reset clears the phase, the queue and the pipeline
// valids, and loads the register defaults; depends on mwpo_pkg and submodules
module multi_waveform_phase_oscillator_core
    import mwpo_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [FREQ_BITS-1:0]   freq,
    input  logic signed [WIDTH_BITS-1:0]  pwm_width,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    logic [SCALE_BITS-1:0] step_scale_reg;
    logic [WAVE_BITS-1:0]  waveform_reg;
    logic                  push;
    logic                  push_ready;
    qent_t                 push_ent;
    logic                  pop_valid;
    logic                  pop;
    qent_t                 pop_ent;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_scale_reg <= STEP_SCALE_RESET;
            waveform_reg   <= WAVEFORM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STEP_SCALE: step_scale_reg <= cfg_data[SCALE_BITS-1:0];
                REG_WAVEFORM:   waveform_reg   <= cfg_data[WAVE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // front end
    mwpo_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .freq       (freq),
        .pwm_width  (pwm_width),
        .step_scale (step_scale_reg),
        .push       (push),
        .push_ready (push_ready),
        .push_ent   (push_ent)
    );

    // decoupling queue
    mwpo_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_ent   (push_ent),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_ent    (pop_ent)
    );

    // back end
    mwpo_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .waveform   (waveform_reg),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_ent    (pop_ent),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (sample)
    );

endmodule

### hdl/mwpo_checker.sv
// port-level checker for the oscillator top level, with its bind
// depends on mwpo_pkg
module mwpo_checker
    import mwpo_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic signed [FREQ_BITS-1:0]   freq,
    input logic signed [WIDTH_BITS-1:0]  pwm_width,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] sample,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input logic [CFG_DATA_BITS-1:0]      cfg_data
);

    logic [WAVE_BITS-1:0] wave_reg;
    logic [2:0]           inflight_reg, inflight_next;
    logic                 in_beat;
    logic                 out_beat;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    // beats in flight
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat)
            inflight_next = inflight_reg + 1'b1;
        else if (out_beat && !in_beat)
            inflight_next = inflight_reg - 1'b1;
    end

    // in-flight count and shadow of the waveform register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg     <= WAVEFORM_RESET;
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (cfg_valid && cfg_ready && (cfg_index == REG_WAVEFORM))
                wave_reg <= cfg_data[WAVE_BITS-1:0];
        end
    end

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample))
        else $error("output beat changed while stalled");

    // no output beat without an input beat behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("output beat with nothing in flight");

    // queue plus two back stages bound the beats in flight
    a_inflight_cap: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("too many beats in flight");

    // square and pulse only give the two rails
    a_two_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (wave_reg == WAVE_SQUARE || wave_reg == WAVE_PULSE)
        |-> sample == Q15_MAX || sample == Q15_MIN)
        else $error("two-level waveform off the rails");

    // unused waveform codes give silence
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (wave_reg == WAVE_SPARE_LO || wave_reg == WAVE_SPARE_HI)
        |-> sample == '0)
        else $error("unused waveform code not silent");

endmodule

bind multi_waveform_phase_oscillator_core mwpo_checker u_checker (.*);

### bench/osc_sample_checker.sv
`timescale 1ns / 100ps
// sample checker for the multi-waveform phase oscillator: tracks register
// writes and input beats, predicts each sample and compares output beats
// depends on mwpo_pkg
module osc_sample_checker
    import mwpo_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [FREQ_BITS-1:0]   freq,
    input  logic signed [WIDTH_BITS-1:0]  pwm_width,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    output int                            mismatches,
    output int                            pending
);

    localparam logic [PHASE_BITS-1:0] HALF_TURN = 1 << (PHASE_BITS - 1);

    int                      quarter_sine [QTAB_N+1];
    logic [PHASE_BITS-1:0]   osc_phase;
    logic [SCALE_BITS-1:0]   scale_reg;
    logic [WAVE_BITS-1:0]    wave_reg;
    logic [SAMPLE_BITS-1:0]  expected_samples [$];
    int                      err_count;

    // quarter-wave sine magnitudes, taylor series to x^13 in q30
    initial
    begin : fill_quarter_sine
        longint unsigned x;
        longint unsigned t;
        longint unsigned v;
        longint          s;
        for (int i = 0; i <= QTAB_N; i++)
        begin
            x = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            t = x;
            s = x;
            for (int n = 1; n <= 6; n++)
            begin
                t = (((t * x) >> 30) * x) >> 30;
                t = t / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    s = s - longint'(t);
                else
                    s = s + longint'(t);
            end
            if (s < 0)
                v = 0;
            else
                v = ((64'(s) * 64'd32768) + (64'd1 << 29)) >> 30;
            if (v > 64'd32768)
                v = 64'd32768;
            quarter_sine[i] = int'(v);
        end
    end

    // waveform value at a phase, saturated to q1.15
    function automatic logic [SAMPLE_BITS-1:0] predict_sample(
        input logic [PHASE_BITS-1:0] ph,
        input logic [WAVE_BITS-1:0]  wave,
        input logic [WIDTH_BITS-1:0] width
    );
        int                          v;
        int                          p16;
        int                          mag_sine;
        logic [SINE_TABLE_BITS+1:0]  k;
        longint unsigned             mag;
        longint unsigned             th;
        p16 = int'(ph >> (PHASE_BITS - 16));
        case (wave)
            WAVE_SINE:
            begin
                k = ph[PHASE_BITS-1 -: SINE_TABLE_BITS+2];
                if (k[SINE_TABLE_BITS])
                    mag_sine = quarter_sine[QTAB_N - int'(k[SINE_TABLE_BITS-1:0])];
                else
                    mag_sine = quarter_sine[k[SINE_TABLE_BITS-1:0]];
                v = k[SINE_TABLE_BITS+1] ? -mag_sine : mag_sine;
            end
            WAVE_SQUARE:
                v = (ph <= HALF_TURN) ? 32767 : -32768;
            WAVE_PULSE:
            begin
                // only the magnitude of the width counts, narrow pulses get a floor
                mag = width[WIDTH_BITS-1] ? (64'd65536 - 64'(width)) : 64'(width);
                th = (mag * 64'd99 * 64'd131072) / 64'd100;
                if (mag * 64'd99 < 64'd32768)
                    th = th + 64'd42949672;
                v = (64'(ph) <= th) ? 32767 : -32768;
            end
            WAVE_SAW_DOWN:
                v = 32768 - p16;
            WAVE_SAW_UP:
                v = p16 - 32768;
            WAVE_TRIANGLE:
                v = (ph <= HALF_TURN) ? (2 * p16 - 32768) : (98304 - 2 * p16);
            default:
                v = 0;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // register writes, output comparison, then prediction for the input beat
    always @(posedge clk or negedge rst_n)
    begin : track_oscillator
        logic [63:0]            product;
        logic [SAMPLE_BITS-1:0] want;
        if (!rst_n)
        begin
            osc_phase = '0;
            scale_reg = STEP_SCALE_RESET;
            wave_reg  = WAVEFORM_RESET;
            err_count = 0;
            expected_samples.delete();
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STEP_SCALE: scale_reg = cfg_data[SCALE_BITS-1:0];
                    REG_WAVEFORM:   wave_reg  = cfg_data[WAVE_BITS-1:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: sample beat %0d with none expected",
                                 $realtime, sample);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample !== want)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("%0t: sample expected %0d, got %0d",
                                     $realtime, $signed(want), sample);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                expected_samples.push_back(predict_sample(osc_phase, wave_reg, pwm_width));
                // signed frequency times unsigned scale, wraps modulo one turn
                product = {{32{freq[FREQ_BITS-1]}}, freq} * {32'b0, scale_reg};
                osc_phase = osc_phase + PHASE_BITS'(product >> (48 - PHASE_BITS));
            end

            pending    <= expected_samples.size();
            mismatches <= err_count;
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// top of the oscillator bench: clock, reset, register writes and input beats;
// depends on mwpo_pkg, multi_waveform_phase_oscillator_core and osc_sample_checker
module testbench;
    import mwpo_pkg::*;

    // with this scale the phase increment equals the freq field
    localparam logic [SCALE_BITS-1:0]     UNIT_SCALE    = 32'h0001_0000;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED    = 2'd3;
    localparam logic [PHASE_BITS-1:0]     HALF_TURN     = 32'h8000_0000;
    localparam int QUIET_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 9;
    localparam int BEATS_PER_PHASE = 78;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic signed [FREQ_BITS-1:0]   freq;
    logic signed [WIDTH_BITS-1:0]  pwm_width;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;

    int                    mismatches;
    int                    pending;
    bit                    idle_en;
    int                    stall_left;
    int                    quiet_cycles;
    logic [PHASE_BITS-1:0] dir_phase;

    multi_waveform_phase_oscillator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .freq      (freq),
        .pwm_width (pwm_width),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    osc_sample_checker sample_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .freq       (freq),
        .pwm_width  (pwm_width),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (sample),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // output backpressure in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 4) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    // cycles without any beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // one register write
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one input beat, with an optional gap ahead of it
    task automatic send_tick(input logic [FREQ_BITS-1:0] f,
                             input logic [WIDTH_BITS-1:0] w);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        freq      <= f;
        pwm_width <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // under the unit scale: sample at the current phase, then land on next_phase
    task automatic visit(input logic [PHASE_BITS-1:0] next_phase,
                         input logic [WIDTH_BITS-1:0] w);
        send_tick(next_phase - dir_phase, w);
        dir_phase = next_phase;
    endtask

    // hold input until every predicted sample has come out
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin : stimulus
        logic [FREQ_BITS-1:0]  f;
        logic [WIDTH_BITS-1:0] w;
        logic [SCALE_BITS-1:0] scale;
        int                    wave_offset;

        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        freq      = '0;
        pwm_width = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_STEP_SCALE;
        cfg_data  = '0;
        idle_en   = 1'b1;
        dir_phase = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sine: quadrant edges, full scale saturates, negative step
        write_reg(REG_STEP_SCALE, UNIT_SCALE);
        write_reg(REG_UNUSED, 32'hA5A5_5A5A);
        write_reg(REG_WAVEFORM, 32'(WAVE_SINE));
        visit(32'h4000_0000, 16'h0000);
        visit(HALF_TURN, 16'h0000);
        visit(32'hC000_0000, 16'h0000);
        visit(32'hBFFF_FFFF, 16'h0000);

        // square around the half turn, freq extremes
        drain();
        write_reg(REG_WAVEFORM, 32'(WAVE_SQUARE));
        visit(HALF_TURN, 16'h0000);
        visit(HALF_TURN + 1, 16'h0000);
        visit(32'h0000_0000, 16'h0000);

        // pulse: widest threshold, narrow floor boundary, width extremes
        drain();
        write_reg(REG_WAVEFORM, 32'(WAVE_PULSE));
        visit(32'd4252017623, 16'h8000);
        visit(32'd4252017624, 16'h8000);
        visit(32'd42951229, 16'h8000);
        visit(32'd42951230, 16'd331);
        visit(32'd42951230, 16'd331);
        visit(32'h0000_0000, 16'd330);
        visit(HALF_TURN, 16'h7FFF);
        visit(32'h0000_0000, 16'h0000);

        // saws at both ends of the turn
        drain();
        write_reg(REG_WAVEFORM, 32'(WAVE_SAW_DOWN));
        visit(32'hFFFF_FFFF, 16'h0000);
        visit(32'h0000_0000, 16'h0000);
        drain();
        write_reg(REG_WAVEFORM, 32'(WAVE_SAW_UP));
        visit(32'hFFFF_FFFF, 16'hFFFF);
        visit(32'h0000_0000, 16'hFFFF);

        // triangle peak at the half turn
        drain();
        write_reg(REG_WAVEFORM, 32'(WAVE_TRIANGLE));
        visit(HALF_TURN, 16'h0000);
        visit(HALF_TURN + 1, 16'h0000);
        visit(32'h0000_0000, 16'h0000);

        // unused codes give zero while the phase still moves
        drain();
        write_reg(REG_WAVEFORM, 32'(WAVE_SPARE_LO));
        visit(32'h1234_5678, 16'h0000);
        drain();
        write_reg(REG_WAVEFORM, 32'(WAVE_SPARE_HI));
        visit(32'h0000_0000, 16'h0000);

        // random phases, each with its own scale and waveform
        wave_offset = $urandom_range(0, (1 << WAVE_BITS) - 1);
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            case (ph)
                0:       scale = 32'hFFFF_FFFF;
                1:       scale = 32'h0000_0000;
                2:       scale = STEP_SCALE_RESET;
                default: scale = ($urandom_range(0, 1) == 0) ? $urandom()
                                 : $urandom_range(1 << 20, 1 << 26);
            endcase
            write_reg(REG_STEP_SCALE, scale);
            write_reg(REG_WAVEFORM, 32'((ph + wave_offset) % (1 << WAVE_BITS)));
            idle_en <= (ph < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);

            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // one pause mid-phase until the pipeline is empty
                if (ph == 4 && n == BEATS_PER_PHASE / 2)
                    drain();
                case ($urandom_range(0, 4))
                    0: f = $urandom();
                    1: f = $urandom_range(5120, 5120000);
                    2: f = -$urandom_range(5120, 5120000);
                    3: f = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: f = $urandom_range(0, 255);
                endcase
                case ($urandom_range(0, 3))
                    0, 1: w = 16'($urandom());
                    2: w = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(325, 336))
                                                       : -16'($urandom_range(325, 336));
                    default:
                        case ($urandom_range(0, 3))
                            0:       w = 16'h7FFF;
                            1:       w = 16'h8000;
                            2:       w = 16'hFFFF;
                            default: w = 16'h0000;
                        endcase
                endcase
                send_tick(f, w);
            end
        end

        // wait out the last samples, then keep the clock running for strays
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
hdl/mwpo_pkg.sv
hdl/mwpo_front.sv
hdl/mwpo_queue.sv
hdl/mwpo_back.sv
hdl/multi_waveform_phase_oscillator_core.sv
hdl/mwpo_checker.sv
bench/osc_sample_checker.sv
bench/testbench.sv
